@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond in one cycle implies expr in the next
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

// cond implies expr in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

@@ sv/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// i2a_pkg
// Types and constants for the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int MAX_WIDTH     = 32;
    localparam int LEN_W         = $clog2(MAX_WIDTH + 1);
    localparam int VALUE_W       = 64;
    localparam int DEC_DIGITS    = 20;
    localparam int DIG_W         = $clog2(DEC_DIGITS + 1);
    localparam int BITS_PER_STEP = 2;
    localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(CONV_STEPS);
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] REQ_SDEC    = 2'd0;
    localparam int         HEX_SEL_BIT = 1;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value_bits;
        logic               narrow;
        logic [5:0]         min_chars;
        logic [7:0]         pad_char;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last;
    } out_item_t;

    // classified number as it waits in the queue
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               negative;
        logic               hex;
        logic [LEN_W-1:0]   width;
        logic [7:0]         pad;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_COUNT,
        BK_EMIT
    } back_state_t;

endpackage

@@ sv/integer_to_ascii_formatter.sv @@
// Decimal numbers pass through the shift-and-add-3 loop, two bits a cycle; hex numbers skip it.
// The characters of each number then leave one a cycle, padded to the requested width.
// Up to four numbers in flight (front register, two-entry queue, back end); busy stalls start.
// Reset (rst_n, asynchronous, active low) empties the queue and idles the back end.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats signed/unsigned decimal or hex integers as padded ASCII characters.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output logic      strobe,
    output out_item_t result
);

    job_t      front_job;
    job_t      head_job;
    logic      push;
    logic      pop;
    q_status_t q_status;

    i2a_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (item),
        .busy     (busy),
        .job      (front_job),
        .push     (push),
        .q_status (q_status)
    );

    i2a_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    (front_job),
        .pop      (pop),
        .rdata    (head_job),
        .q_status (q_status)
    );

    i2a_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (head_job),
        .q_status (q_status),
        .pop      (pop),
        .strobe   (strobe),
        .result   (result)
    );

endmodule

@@ sv/i2a_front.sv @@
// ----------------------------------------------------------------------------
// i2a_front
// Takes a number beat, extends it, splits off the sign and saturates the width.
// ----------------------------------------------------------------------------
module i2a_front
    import i2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  in_item_t  item,
    output logic      busy,
    output job_t      job,
    output logic      push,
    input  q_status_t q_status
);

    logic               valid_reg, valid_next;
    job_t               job_reg, job_next;
    logic               signed_mode;
    logic [VALUE_W-1:0] ext_value;
    logic               negative;
    logic [6:0]         wide_width;

    always_comb
    begin
        signed_mode = (item.req_type == REQ_SDEC);
        if (item.narrow)
        begin
            ext_value = {{32{signed_mode & item.value_bits[31]}}, item.value_bits[31:0]};
        end
        else
        begin
            ext_value = item.value_bits;
        end
        negative   = signed_mode & ext_value[VALUE_W-1];
        wide_width = {1'b0, item.min_chars};

        job_next.negative = negative;
        job_next.mag      = negative ? (~ext_value + {{(VALUE_W-1){1'b0}}, 1'b1}) : ext_value;
        job_next.hex      = item.req_type[HEX_SEL_BIT];
        job_next.pad      = item.pad_char;
        if (wide_width > 7'(MAX_WIDTH))
        begin
            job_next.width = LEN_W'(MAX_WIDTH);
        end
        else
        begin
            job_next.width = LEN_W'(wide_width);
        end
    end

    assign push = valid_reg & ~q_status.full;
    assign busy = valid_reg;
    assign job  = job_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (start && !valid_reg)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !valid_reg)
        begin
            job_reg <= job_next;
        end
    end

endmodule

@@ sv/i2a_queue.sv @@
// ----------------------------------------------------------------------------
// i2a_queue
// Short queue of classified numbers between front and back.
// ----------------------------------------------------------------------------
module i2a_queue
    import i2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  job_t      wdata,
    input  logic      pop,
    output job_t      rdata,
    output q_status_t q_status
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign do_push        = push & ~q_status.full;
    assign do_pop         = pop & ~q_status.empty;
    assign rdata          = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

@@ sv/i2a_back.sv @@
// ----------------------------------------------------------------------------
// i2a_back
// Converts a queued number to digits and emits the characters one a cycle.
// ----------------------------------------------------------------------------
module i2a_back
    import i2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  job_t      job,
    input  q_status_t q_status,
    output logic      pop,
    output logic      strobe,
    output out_item_t result
);

    localparam int BCD_W = 4 * DEC_DIGITS;

    back_state_t        state_reg, state_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               neg_reg, neg_next;
    logic [LEN_W-1:0]   width_reg, width_next;
    logic [7:0]         pad_reg, pad_next;
    logic [DIG_W-1:0]   ndig_reg, ndig_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [LEN_W-1:0]   pos_reg, pos_next;
    logic               strobe_reg, strobe_next;
    out_item_t          result_reg, result_next;

    logic [BCD_W-1:0]   adj1, adj2, shift1;
    logic [VALUE_W-1:0] bin1;
    logic [DIG_W-1:0]   ndig_calc;
    logic [LEN_W-1:0]   body_len;
    logic [LEN_W-1:0]   pads;
    logic [LEN_W-1:0]   digit_pos;
    logic [3:0]         digit;
    logic               is_last;

    // double-dabble correction: every BCD digit of five or more gets three added
    function automatic logic [BCD_W-1:0] dabble_adj(input logic [BCD_W-1:0] d);
        logic [BCD_W-1:0] r;
        r = d;
        for (int i = 0; i < DEC_DIGITS; i++)
        begin
            if (d[4*i +: 4] >= 4'd5)
            begin
                r[4*i +: 4] = d[4*i +: 4] + 4'd3;
            end
        end
        return r;
    endfunction

    function automatic logic [DIG_W-1:0] count_digits(input logic [BCD_W-1:0] d);
        logic [DIG_W-1:0] c;
        c = DIG_W'(1);
        for (int i = 1; i < DEC_DIGITS; i++)
        begin
            if (d[4*i +: 4] != 4'd0)
            begin
                c = DIG_W'(i + 1);
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return CHAR_ZERO + {4'b0000, d};
        end
        return CHAR_LOW_A + {4'b0000, d} - 8'd10;
    endfunction

    // two shift steps per cycle
    always_comb
    begin
        adj1   = dabble_adj(bcd_reg);
        shift1 = {adj1[BCD_W-2:0], bin_reg[VALUE_W-1]};
        bin1   = {bin_reg[VALUE_W-2:0], 1'b0};
        adj2   = dabble_adj(shift1);
    end

    always_comb
    begin
        ndig_calc = count_digits(bcd_reg);
        body_len  = LEN_W'(ndig_calc) + LEN_W'(neg_reg);
        pads      = len_reg - LEN_W'(ndig_reg) - LEN_W'(neg_reg);
        digit_pos = len_reg - LEN_W'(1) - pos_reg;
        // only read in the digit span, where the position is below DEC_DIGITS
        digit     = bcd_reg[{digit_pos[DIG_W-1:0], 2'b00} +: 4];
        is_last   = (pos_reg == len_reg - LEN_W'(1));
    end

    always_comb
    begin
        state_next  = state_reg;
        bcd_next    = bcd_reg;
        bin_next    = bin_reg;
        step_next   = step_reg;
        neg_next    = neg_reg;
        width_next  = width_reg;
        pad_next    = pad_reg;
        ndig_next   = ndig_reg;
        len_next    = len_reg;
        pos_next    = pos_reg;
        strobe_next = 1'b0;
        result_next = result_reg;
        pop         = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    neg_next   = job.negative;
                    width_next = job.width;
                    pad_next   = job.pad;
                    if (job.hex)
                    begin
                        bcd_next   = {{(BCD_W - VALUE_W){1'b0}}, job.mag};
                        state_next = BK_COUNT;
                    end
                    else
                    begin
                        bcd_next   = '0;
                        bin_next   = job.mag;
                        step_next  = '0;
                        state_next = BK_CONV;
                    end
                end
            end
            BK_CONV:
            begin
                bcd_next  = {adj2[BCD_W-2:0], bin1[VALUE_W-1]};
                bin_next  = {bin1[VALUE_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(CONV_STEPS - 1))
                begin
                    state_next = BK_COUNT;
                end
            end
            BK_COUNT:
            begin
                ndig_next  = ndig_calc;
                len_next   = (body_len > width_reg) ? body_len : width_reg;
                pos_next   = '0;
                state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                strobe_next      = 1'b1;
                result_next.last = is_last;
                priority if (pos_reg < pads)
                begin
                    result_next.out_char = pad_reg;
                end
                else if (neg_reg && (pos_reg == pads))
                begin
                    result_next.out_char = CHAR_MINUS;
                end
                else
                begin
                    result_next.out_char = digit_char(digit);
                end
                pos_next = pos_reg + LEN_W'(1);
                if (is_last)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            step_reg   <= '0;
            pos_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg    <= bcd_next;
        bin_reg    <= bin_next;
        neg_reg    <= neg_next;
        width_reg  <= width_next;
        pad_reg    <= pad_next;
        ndig_reg   <= ndig_next;
        len_reg    <= len_next;
        result_reg <= result_next;
    end

endmodule

@@ sv/i2a_checker.sv @@
// ----------------------------------------------------------------------------
// i2a_checker
// Port-level checks on the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module i2a_checker
    import i2a_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      start,
    input in_item_t  item,
    input logic      busy,
    input logic      strobe,
    input out_item_t result
);

    logic accept;

    assign accept = start & ~busy;

    // front holds an accepted beat, so busy is set after it
    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy, "busy low after accepted beat")
    // busy only rises after an accepted beat
    `ASSERT_IMPL(a_busy_cause, clk, rst_n, $rose(busy), $past(accept), "busy rose unprompted")
    // characters of one number come without gaps
    `ASSERT_NEXT(a_no_gap, clk, rst_n, strobe && !result.last, strobe, "gap inside a number")
    // a fresh number is never glued to the previous one
    `ASSERT_NEXT(a_idle_after_last, clk, rst_n, strobe && result.last, !strobe,
                 "character straight after last")

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);
